FILE: rtl/ham6_pkg.sv
// Shared types, palette ROM and distance helpers for the HAM6 pixel encoder.
`default_nettype none

package ham6_pkg;

    localparam int PAL_SIZE = 16;
    localparam int IDX_W    = 4;
    localparam int SQ_W     = 16;
    localparam int DIST_W   = 18;
    localparam int CODE_W   = 6;

    // Code prefixes for the three modify operations
    localparam logic [CODE_W-1:0] TAG_RED   = 6'h20;
    localparam logic [CODE_W-1:0] TAG_GREEN = 6'h30;
    localparam logic [CODE_W-1:0] TAG_BLUE  = 6'h10;

    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Palette search winner
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        dist_t            distance;
    } pal_best_t;

    // Final decision for one pixel: emitted code and new held color
    typedef struct packed {
        logic [CODE_W-1:0] code;
        rgb_t              held;
    } ham_choice_t;

    localparam rgb_t PAL_ROM [PAL_SIZE] = '{
        '{8'h02, 8'h02, 8'h24}, '{8'h02, 8'hFE, 8'h44},
        '{8'hFE, 8'h02, 8'h59}, '{8'h02, 8'h7E, 8'h3A},
        '{8'hFE, 8'hFE, 8'h49}, '{8'h7E, 8'h02, 8'h42},
        '{8'h7E, 8'hFE, 8'h3E}, '{8'hFE, 8'h7E, 8'h85},
        '{8'h7E, 8'h7E, 8'h77}, '{8'h02, 8'h02, 8'hFC},
        '{8'h02, 8'hFE, 8'hFC}, '{8'hFE, 8'h02, 8'hFC},
        '{8'h02, 8'h7E, 8'hFC}, '{8'hFE, 8'hFE, 8'hFC},
        '{8'h7E, 8'h02, 8'hFC}, '{8'h7E, 8'hFE, 8'hFC}
    };

    // Square of the absolute difference of two bytes
    function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0]      d;
        logic [SQ_W-1:0] dw;
        d  = (a > b) ? (a - b) : (b - a);
        dw = {8'h00, d};
        return dw * dw;
    endfunction

    // Squared Euclidean distance between two colors
    function automatic dist_t color_dist(input rgb_t a, input rgb_t b);
        return DIST_W'(sq_diff(a.red, b.red)) + DIST_W'(sq_diff(a.green, b.green))
             + DIST_W'(sq_diff(a.blue, b.blue));
    endfunction

    // Nibble of a byte copied into both halves
    function automatic logic [7:0] nib_rep(input logic [7:0] v);
        return {v[7:4], v[7:4]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ham6_pal_search.sv
// Palette search: nearest ROM entry by squared distance, ties to the highest index.
`default_nettype none

module ham6_pal_search (
    input  ham6_pkg::rgb_t      pix,
    output ham6_pkg::pal_best_t best
);
    import ham6_pkg::*;

    pal_best_t lvl0 [PAL_SIZE];
    pal_best_t lvl1 [PAL_SIZE/2];
    pal_best_t lvl2 [PAL_SIZE/4];
    pal_best_t lvl3 [PAL_SIZE/8];

    // Upper entry wins on equal distance
    function automatic pal_best_t pick(input pal_best_t lo, input pal_best_t hi);
        return (hi.distance <= lo.distance) ? hi : lo;
    endfunction

    // Distance to every palette entry
    always_comb
    begin
        for (int i = 0; i < PAL_SIZE; i++)
        begin
            lvl0[i].idx      = IDX_W'(i);
            lvl0[i].distance = color_dist(PAL_ROM[i], pix);
        end
    end

    // Reduce through a four-level minimum tree
    always_comb
    begin
        for (int i = 0; i < PAL_SIZE/2; i++)
        begin
            lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
        end
        for (int i = 0; i < PAL_SIZE/4; i++)
        begin
            lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
        end
        for (int i = 0; i < PAL_SIZE/8; i++)
        begin
            lvl3[i] = pick(lvl2[2*i], lvl2[2*i+1]);
        end
    end

    assign best = pick(lvl3[0], lvl3[1]);

endmodule

`default_nettype wire

FILE: rtl/ham6_mod_select.sv
// Compare palette reload against the three single-component modifies of the held color.
`default_nettype none

module ham6_mod_select (
    input  ham6_pkg::rgb_t        pix,
    input  ham6_pkg::rgb_t        held,
    input  logic                  first,
    input  ham6_pkg::pal_best_t   best,
    output ham6_pkg::ham_choice_t choice
);
    import ham6_pkg::*;

    logic [7:0] mod_r;
    logic [7:0] mod_g;
    logic [7:0] mod_b;
    dist_t      held_dist;
    dist_t      md_r;
    dist_t      md_g;
    dist_t      md_b;
    dist_t      mmin;
    logic       pick_r;
    logic       pick_g;
    logic       reload;

    assign mod_r = nib_rep(pix.red);
    assign mod_g = nib_rep(pix.green);
    assign mod_b = nib_rep(pix.blue);

    // Swap one component's term out of the held-color distance
    assign held_dist = color_dist(held, pix);
    assign md_r = held_dist - DIST_W'(sq_diff(held.red, pix.red))
                + DIST_W'(sq_diff(mod_r, pix.red));
    assign md_g = held_dist - DIST_W'(sq_diff(held.green, pix.green))
                + DIST_W'(sq_diff(mod_g, pix.green));
    assign md_b = held_dist - DIST_W'(sq_diff(held.blue, pix.blue))
                + DIST_W'(sq_diff(mod_b, pix.blue));

    // First minimal component in red, green, blue order
    assign pick_r = (md_r <= md_g) && (md_r <= md_b);
    assign pick_g = !pick_r && (md_g <= md_b);
    assign mmin   = pick_r ? md_r : (pick_g ? md_g : md_b);

    // Reload only on a line start or when strictly nearer
    assign reload = first || (best.distance < mmin);

    always_comb
    begin
        choice.held = held;
        if (reload)
        begin
            choice.code = CODE_W'(best.idx);
            choice.held = PAL_ROM[best.idx];
        end
        else if (pick_r)
        begin
            choice.code     = TAG_RED | CODE_W'(pix.red[7:4]);
            choice.held.red = mod_r;
        end
        else if (pick_g)
        begin
            choice.code       = TAG_GREEN | CODE_W'(pix.green[7:4]);
            choice.held.green = mod_g;
        end
        else
        begin
            choice.code      = TAG_BLUE | CODE_W'(pix.blue[7:4]);
            choice.held.blue = mod_b;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ham6_pixel_encoder_unit.sv
// Top level of the HAM6 pixel encoder: input register, encode logic, result register.
//
// Usage:
//   Pixels enter on the in_valid/in_ready channel, one beat per pixel with
//   red, green, blue, alpha and first_in_line. Each pixel yields exactly one
//   result beat on out_valid/out_ready carrying ham_code and alpha_out.
//   The alpha_present register is written through cfg_valid/cfg_ready with
//   cfg_data; cfg_ready is always high. Write it only while no pixel is in
//   flight.
//   An accepted pixel moves from the input register to the result register
//   once that is free. Throughput: one pixel per cycle while out_ready stays
//   high; the palette search and modify compare sit between the two registers,
//   and the held color is updated at the same edge the result is loaded.
//   Reset clears both stage valids, the held color to black and
//   alpha_present to zero.
//   When out_ready is low the result holds, and one more pixel is still taken
//   into the input register; in_ready then drops until the result drains.
`default_nettype none

module ham6_pixel_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       first_in_line,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] ham_code,
    output logic [7:0] alpha_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import ham6_pkg::*;

    logic                  in_valid_reg;
    rgb_t                  pix_reg;
    logic [7:0]            alpha_reg;
    logic                  first_reg;
    logic                  out_valid_reg;
    logic [CODE_W-1:0]     ham_code_reg;
    logic [7:0]            alpha_out_reg;
    rgb_t                  held_reg;
    logic                  alpha_present_reg;
    logic                  in_fire;
    logic                  advance;
    pal_best_t             best;
    ham_choice_t           choice;

    // Move a beat from the input register into the result register
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    ham6_pal_search u_pal (
        .pix  (pix_reg),
        .best (best)
    );

    ham6_mod_select u_mod (
        .pix    (pix_reg),
        .held   (held_reg),
        .first  (first_reg),
        .best   (best),
        .choice (choice)
    );

    // Control state, held color and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            held_reg          <= '0;
            alpha_present_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= choice.held;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                alpha_present_reg <= cfg_data;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_reg   <= '{red, green, blue};
            alpha_reg <= alpha;
            first_reg <= first_in_line;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ham_code_reg  <= choice.code;
            alpha_out_reg <= alpha_present_reg ? alpha_reg : 8'h00;
        end
    end

    assign out_valid = out_valid_reg;
    assign ham_code  = ham_code_reg;
    assign alpha_out = alpha_out_reg;

    // A line start always reloads, and the held color becomes that palette entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && first_reg) |=> (ham_code[5:4] == 2'b00)
            && (held_reg == PAL_ROM[ham_code[3:0]]))
        else $error("line start did not reload the held color from the palette");

    // A red modify leaves the replicated nibble in the held red
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (ham_code[5:4] != TAG_RED[5:4])
            || (held_reg.red == {ham_code[3:0], ham_code[3:0]}))
        else $error("held red does not match the modify code");

    // A green modify leaves the replicated nibble in the held green
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (ham_code[5:4] != TAG_GREEN[5:4])
            || (held_reg.green == {ham_code[3:0], ham_code[3:0]}))
        else $error("held green does not match the modify code");

    // A blue modify leaves the replicated nibble in the held blue
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (ham_code[5:4] != TAG_BLUE[5:4])
            || (held_reg.blue == {ham_code[3:0], ham_code[3:0]}))
        else $error("held blue does not match the modify code");

endmodule

`default_nettype wire

FILE: dv/ham6_pixel_encoder_unit_tb.sv
// Self-checking testbench for the HAM6 pixel encoder: random line traffic, scoreboard, idling.
`default_nettype none

module ham6_pixel_encoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PAL_ENTRIES  = 16;
    localparam int SHOWN_ERRORS = 10;

    // Component positions inside a packed {red, green, blue} color
    localparam int C_RED   = 0;
    localparam int C_GREEN = 1;
    localparam int C_BLUE  = 2;

    // Code prefixes of the three modify operations
    localparam logic [5:0] MOD_RED   = 6'h20;
    localparam logic [5:0] MOD_GREEN = 6'h30;
    localparam logic [5:0] MOD_BLUE  = 6'h10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       first_px;
    } pixel_beat_t;

    typedef struct packed {
        logic [5:0] code;
        logic [7:0] alpha;
    } ham_result_t;

    typedef enum int {LINE_GRADIENT, LINE_SCATTER, LINE_NIBBLE, LINE_PALETTE} line_style_t;
    typedef enum int {START_MARKED, START_MISSING, START_RANDOM} line_start_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] red           = 8'h00;
    logic [7:0] green         = 8'h00;
    logic [7:0] blue          = 8'h00;
    logic [7:0] alpha         = 8'h00;
    logic       first_in_line = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [5:0] ham_code;
    logic [7:0] alpha_out;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic       cfg_data      = 1'b0;

    pixel_beat_t pixel_queue [$];
    ham_result_t expected_codes [$];

    logic [23:0] held_rgb     = 24'h000000;
    logic        alpha_enable = 1'b0;
    int          stim_count   = 0;
    int          error_count  = 0;
    int          cycle_count  = 0;
    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int          sender_burst      = 0;
    int          receiver_burst    = 0;

    ham6_pixel_encoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .first_in_line (first_in_line),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ham_code      (ham_code),
        .alpha_out     (alpha_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #4ns clk = ~clk;

    // Fixed palette, packed as {red, green, blue}
    function automatic logic [23:0] palette_entry(input int idx);
        case (idx)
            0:       return 24'h020224;
            1:       return 24'h02FE44;
            2:       return 24'hFE0259;
            3:       return 24'h027E3A;
            4:       return 24'hFEFE49;
            5:       return 24'h7E0242;
            6:       return 24'h7EFE3E;
            7:       return 24'hFE7E85;
            8:       return 24'h7E7E77;
            9:       return 24'h0202FC;
            10:      return 24'h02FEFC;
            11:      return 24'hFE02FC;
            12:      return 24'h027EFC;
            13:      return 24'hFEFEFC;
            14:      return 24'h7E02FC;
            default: return 24'h7EFEFC;
        endcase
    endfunction

    function automatic logic [5:0] modify_tag(input int comp);
        case (comp)
            C_RED:   return MOD_RED;
            C_GREEN: return MOD_GREEN;
            default: return MOD_BLUE;
        endcase
    endfunction

    // Squared Euclidean distance between two packed colors
    function automatic int unsigned rgb_dist(input logic [23:0] a, input logic [23:0] b);
        int unsigned total;
        int          av;
        int          bv;
        total = 0;
        for (int c = 0; c < 3; c++) begin
            av = a[23-8*c -: 8];
            bv = b[23-8*c -: 8];
            total += (av - bv) * (av - bv);
        end
        return total;
    endfunction

    // Encode one accepted pixel: advance the held color and queue the expected beat
    function automatic void encode_pixel(input pixel_beat_t px);
        logic [23:0] target;
        logic [23:0] trial;
        logic [7:0]  tv;
        logic [3:0]  best_idx;
        int unsigned best;
        int unsigned mod_dist [3];
        int unsigned mod_min;
        int          pick;
        ham_result_t res;
        target   = {px.red, px.green, px.blue};
        best     = 32'hFFFF_FFFF;
        best_idx = 4'd0;
        // scan down so that ties keep the highest index
        for (int i = PAL_ENTRIES - 1; i >= 0; i--) begin
            if (rgb_dist(palette_entry(i), target) < best) begin
                best     = rgb_dist(palette_entry(i), target);
                best_idx = 4'(i);
            end
        end
        mod_min = 32'hFFFF_FFFF;
        for (int c = 0; c < 3; c++) begin
            tv    = target[23-8*c -: 8];
            trial = held_rgb;
            trial[23-8*c -: 8] = {tv[7:4], tv[7:4]};
            mod_dist[c] = rgb_dist(trial, target);
            if (mod_dist[c] < mod_min)
                mod_min = mod_dist[c];
        end
        if (px.first_px || best < mod_min) begin
            res.code = {2'b00, best_idx};
            held_rgb = palette_entry(best_idx);
        end
        else begin
            pick = (mod_dist[C_RED] == mod_min) ? C_RED :
                   (mod_dist[C_GREEN] == mod_min) ? C_GREEN : C_BLUE;
            tv = target[23-8*pick -: 8];
            res.code = modify_tag(pick) | {2'b00, tv[7:4]};
            held_rgb[23-8*pick -: 8] = {tv[7:4], tv[7:4]};
        end
        res.alpha = alpha_enable ? px.alpha : 8'h00;
        expected_codes.push_back(res);
    endfunction

    function automatic void flag_mismatch(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("ERROR: %s", msg);
    endfunction

    // Move a byte by a random amount, clamped to 0..255
    function automatic logic [7:0] nudge_byte(input logic [7:0] v, input int span);
        int r;
        r = int'(v) + $urandom_range(2 * span, 0) - span;
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        return 8'(r);
    endfunction

    function automatic void add_pixel(input logic [23:0] color, input logic [7:0] a,
                                      input logic first_px);
        pixel_beat_t px;
        px.red      = color[23:16];
        px.green    = color[15:8];
        px.blue     = color[7:0];
        px.alpha    = a;
        px.first_px = first_px;
        pixel_queue.push_back(px);
        stim_count++;
    endfunction

    // One scanline of random content in one of several color styles
    function automatic void add_line(input int len, input line_start_t start);
        logic [23:0] color;
        logic [3:0]  nib;
        logic        first_px;
        int          comp;
        line_style_t style;
        style = line_style_t'($urandom_range(3, 0));
        color = (style == LINE_PALETTE) ? palette_entry($urandom_range(15, 0)) : 24'($urandom);
        for (int n = 0; n < len; n++) begin
            case (style)
                LINE_GRADIENT: color = {nudge_byte(color[23:16], 12), nudge_byte(color[15:8], 12),
                                        nudge_byte(color[7:0], 12)};
                LINE_SCATTER:  color = 24'($urandom);
                LINE_NIBBLE:
                begin
                    comp = $urandom_range(2, 0);
                    nib  = 4'($urandom_range(15, 0));
                    color[23-8*comp -: 8] = {nib, nib};
                end
                default:
                begin
                    color = palette_entry($urandom_range(15, 0));
                    color = {nudge_byte(color[23:16], 10), nudge_byte(color[15:8], 10),
                             nudge_byte(color[7:0], 10)};
                end
            endcase
            case (start)
                START_MARKED:  first_px = (n == 0);
                START_MISSING: first_px = 1'b0;
                default:       first_px = 1'($urandom);
            endcase
            add_pixel(color, 8'($urandom), first_px);
        end
    endfunction

    // Mostly well-formed lines, the rest broken lines and stray pixels
    function automatic void add_random_stretch(input int count);
        int start_count;
        int kind;
        start_count = stim_count;
        while (stim_count - start_count < count) begin
            kind = $urandom_range(9, 0);
            if (kind < 7)
                add_line($urandom_range(32, 2), START_MARKED);
            else if (kind < 9)
                add_line($urandom_range(8, 1), START_RANDOM);
            else
                add_line($urandom_range(12, 1), START_MISSING);
        end
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pixel_queue.size() != 0 || in_valid || expected_codes.size() != 0);
    endtask

    task automatic write_alpha_present(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Track the register as the block sees it
    always @(posedge clk) begin
        if (rst_n && cfg_valid && cfg_ready)
            alpha_enable <= cfg_data;
    end

    // Pixel driver: hold a beat until taken, then load the next one or idle
    always @(posedge clk) begin
        bit hold_off;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready)
                encode_pixel('{red, green, blue, alpha, first_in_line});
            if (!in_valid || in_ready) begin
                if (sender_burst > 0) begin
                    sender_burst--;
                    hold_off = 1'b0;
                end
                else if ($urandom_range(99, 0) < 3) begin
                    sender_burst = $urandom_range(40, 8);
                    hold_off     = 1'b0;
                end
                else begin
                    hold_off = ($urandom_range(99, 0) < sender_idle_pct);
                end
                if (pixel_queue.size() != 0 && !hold_off) begin
                    red           <= pixel_queue[0].red;
                    green         <= pixel_queue[0].green;
                    blue          <= pixel_queue[0].blue;
                    alpha         <= pixel_queue[0].alpha;
                    first_in_line <= pixel_queue[0].first_px;
                    in_valid      <= 1'b1;
                    void'(pixel_queue.pop_front());
                end
                else begin
                    // scramble the payload while no beat is offered
                    red           <= 8'($urandom);
                    green         <= 8'($urandom);
                    blue          <= 8'($urandom);
                    alpha         <= 8'($urandom);
                    first_in_line <= 1'($urandom);
                    in_valid      <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest expectation, stall at random
    always @(posedge clk) begin
        ham_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_codes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat: code %0h alpha %0h",
                                            ham_code, alpha_out));
                end
                else begin
                    want = expected_codes.pop_front();
                    if (ham_code !== want.code || alpha_out !== want.alpha)
                        flag_mismatch($sformatf(
                            "expected code %0h alpha %0h, got code %0h alpha %0h",
                            want.code, want.alpha, ham_code, alpha_out));
                end
            end
            if (receiver_burst > 0) begin
                receiver_burst--;
                out_ready <= 1'b1;
            end
            else if ($urandom_range(99, 0) < 3) begin
                receiver_burst = $urandom_range(40, 8);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= !($urandom_range(99, 0) < receiver_idle_pct);
            end
        end
    end

    // Hard stop for a hung handshake
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender mostly busy, receiver mostly stalled
        sender_idle_pct   = 13;
        receiver_idle_pct = 85;

        // directed: black target with no line start after reset, then extremes,
        // a palette tie, a reload/modify tie and single-component modifies
        add_pixel(24'h000000, 8'h00, 1'b0);
        wait_idle();
        write_alpha_present(1'b1);
        add_pixel(24'hFFFFFF, 8'hFF, 1'b1);
        add_pixel(24'h020290, 8'h55, 1'b1);
        add_pixel(24'h7E7E77, 8'hAA, 1'b1);
        add_pixel(24'h7E7E77, 8'h01, 1'b0);
        add_pixel(24'hF37E77, 8'h80, 1'b0);
        add_pixel(24'hF3C077, 8'h7F, 1'b0);
        add_pixel(24'hF3C01E, 8'hFE, 1'b0);
        add_pixel(24'h000000, 8'h00, 1'b0);
        add_pixel(24'hFFFFFF, 8'hFF, 1'b0);
        add_pixel(24'h00FF00, 8'h5A, 1'b1);
        add_pixel(24'hFF00FF, 8'hA5, 1'b0);
        add_pixel(24'h808080, 8'h0F, 1'b0);
        add_pixel(24'h01FE7F, 8'hF0, 1'b0);
        add_pixel(24'h0202FC, 8'h33, 1'b1);
        add_pixel(24'h1202FC, 8'hCC, 1'b0);
        add_pixel(24'h1212FC, 8'h66, 1'b0);
        add_pixel(24'h121244, 8'h99, 1'b0);
        add_pixel(24'hFEFEFC, 8'h11, 1'b0);
        add_pixel(24'h7E02FC, 8'hEE, 1'b0);
        wait_idle();

        write_alpha_present(1'b0);
        add_random_stretch(430);
        wait_idle();

        // sender mostly idle, receiver mostly ready
        sender_idle_pct   = 85;
        receiver_idle_pct = 13;
        write_alpha_present(1'b1);
        add_random_stretch(430);
        wait_idle();

        // full rate on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_alpha_present(1'b0);
        add_random_stretch(220);
        wait_idle();
        write_alpha_present(1'b1);
        add_random_stretch(220);
        wait_idle();

        // let any stray beat show up
        repeat (8) @(posedge clk);
        if (expected_codes.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_codes.size()));

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/ham6_pkg.sv
rtl/ham6_pal_search.sv
rtl/ham6_mod_select.sv
rtl/ham6_pixel_encoder_unit.sv
dv/ham6_pixel_encoder_unit_tb.sv
